>>> design/usc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_pkg
// Shared constants, types and helpers for the superblock classifier.
// ----------------------------------------------------------------------------
package usc_pkg;

  localparam int unsigned PosW = 9;

  localparam logic [PosW-1:0] WordsPerBlock = 9'd256;
  localparam logic [PosW-1:0] PosIsize      = 9'd0;
  localparam logic [PosW-1:0] PosSizeOne    = 9'd1;
  localparam logic [PosW-1:0] PosSizeTwo    = 9'd2;
  localparam logic [PosW-1:0] PosV7Free     = 9'd3;
  localparam logic [PosW-1:0] PosV6Inode    = 9'd103;
  localparam logic [PosW-1:0] PosV7Inode    = 9'd104;

  // Free lists: V6 entries are single words from word 3, V7 entries are
  // word pairs from word 4.
  localparam logic [PosW-1:0] V6ListFirst = 9'd3;
  localparam logic [PosW-1:0] V6ListEnd   = 9'd103;
  localparam logic [PosW-1:0] V7ListFirst = 9'd4;
  localparam logic [PosW-1:0] V7ListEnd   = 9'd104;

  localparam logic [15:0] V7FreeMax = 16'd50;
  localparam logic [15:0] V6FreeMax = 16'd100;
  localparam logic [15:0] InodeMax  = 16'd100;
  localparam logic [15:0] MinIsize  = 16'd3;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_V7   = 2'd1,
    KIND_32V  = 2'd2,
    KIND_V6   = 2'd3
  } fs_kind_e;

  // Header fields and free-list verdicts gathered over one block.
  typedef struct packed {
    logic [15:0] isize;
    logic [15:0] size_one;
    logic [15:0] size_two;
    logic [15:0] v7_free_count;
    logic [15:0] v7_inode_count;
    logic [15:0] v6_inode_count;
    logic        pdp_ok;
    logic        vax_ok;
    logic        v6_ok;
  } blk_state_t;

  localparam blk_state_t BlkStateClear = '{
    isize:          16'd0,
    size_one:       16'd0,
    size_two:       16'd0,
    v7_free_count:  16'd0,
    v7_inode_count: 16'd0,
    v6_inode_count: 16'd0,
    pdp_ok:         1'b1,
    vax_ok:         1'b1,
    v6_ok:          1'b1
  };

  // A free block number is fine when it is zero or inside [isize, fsize).
  function automatic logic entry_ok(logic [31:0] fb, logic [15:0] isize,
                                    logic [31:0] fsize);
    return (fb == 32'd0) || ((fb >= {16'd0, isize}) && (fb < fsize));
  endfunction

endpackage

>>> design/usc_block_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_block_state
// Word position, captured header fields and running free-list checks.
// ----------------------------------------------------------------------------
module usc_block_state import usc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_en_i,
  input  logic [15:0] word_i,
  input  logic        last_i,
  output blk_state_t  state_next_o
);

  blk_state_t      st_q, st_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     pend_q, pend_d;

  logic [15:0] pos_wide;
  logic [15:0] v7_second;
  logic        v6_in_list;
  logic        v7_in_list;
  logic        v7_check;

  assign pos_wide = {{(16-PosW){1'b0}}, pos_q};

  assign v6_in_list = (pos_q >= V6ListFirst) && (pos_q < V6ListEnd) &&
                      ((pos_wide - {{(16-PosW){1'b0}}, V6ListFirst}) < st_q.size_two);
  assign v7_in_list = (pos_q >= V7ListFirst) && (pos_q < V7ListEnd) &&
                      (((pos_wide - {{(16-PosW){1'b0}}, V7ListFirst}) >> 1)
                       < st_q.v7_free_count);

  // The first half of a pair is checked alone, with a zero second half,
  // only when the block ends on it.
  always_comb begin
    logic [15:0] first;
    first     = pos_q[0] ? pend_q : word_i;
    v7_second = pos_q[0] ? word_i : 16'd0;
    v7_check  = v7_in_list && (pos_q[0] || last_i);
    st_d      = st_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    if (pos_q < WordsPerBlock) begin
      case (pos_q)
        PosIsize:   st_d.isize          = word_i;
        PosSizeOne: st_d.size_one       = word_i;
        PosSizeTwo: st_d.size_two       = word_i;
        PosV7Free:  st_d.v7_free_count  = word_i;
        PosV6Inode: st_d.v6_inode_count = word_i;
        PosV7Inode: st_d.v7_inode_count = word_i;
        default: ;
      endcase
      if (v6_in_list && !entry_ok({16'd0, word_i}, st_q.isize, {16'd0, st_q.size_one})) begin
        st_d.v6_ok = 1'b0;
      end
      if (v7_in_list && !pos_q[0]) begin
        pend_d = word_i;
      end
      if (v7_check) begin
        if (!entry_ok({first, v7_second}, st_q.isize, {st_q.size_one, st_q.size_two})) begin
          st_d.pdp_ok = 1'b0;
        end
        if (!entry_ok({v7_second, first}, st_q.isize, {st_q.size_two, st_q.size_one})) begin
          st_d.vax_ok = 1'b0;
        end
      end
      pos_d = pos_q + 1'b1;
    end
  end

  assign state_next_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BlkStateClear;
      pos_q  <= '0;
      pend_q <= '0;
    end else if (beat_en_i) begin
      if (last_i) begin
        st_q   <= BlkStateClear;
        pos_q  <= '0;
        pend_q <= '0;
      end else begin
        st_q   <= st_d;
        pos_q  <= pos_d;
        pend_q <= pend_d;
      end
    end
  end

endmodule

>>> design/usc_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_verdict
// Picks the layout for a finished block and holds the result beat.
// ----------------------------------------------------------------------------
module usc_verdict import usc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  blk_state_t  state_i,
  input  logic [31:0] block_number_i,
  input  logic [31:0] image_blocks_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output fs_kind_e    fs_kind_o,
  output logic [15:0] inode_area_blocks_o,
  output logic [31:0] fs_blocks_o
);

  // The filesystem must end after the inode area and inside the image.
  function automatic logic fits(logic [31:0] fsize, logic [15:0] isize,
                                logic [31:0] bno, logic [31:0] img);
    return (fsize > {16'd0, isize}) &&
           (({1'b0, bno} + {1'b0, fsize}) <= ({1'b0, img} + 33'd1));
  endfunction

  logic [31:0] size_pdp, size_vax, size_v6;
  logic        v7_common, v6_common;
  logic        pdp_fit, vax_fit, v6_fit;
  fs_kind_e    kind_d;
  logic [15:0] isz_d;
  logic [31:0] fsz_d;

  logic        valid_q;
  fs_kind_e    kind_q;
  logic [15:0] isz_q;
  logic [31:0] fsz_q;

  assign size_pdp = {state_i.size_one, state_i.size_two};
  assign size_vax = {state_i.size_two, state_i.size_one};
  assign size_v6  = {16'd0, state_i.size_one};

  assign v7_common = (state_i.v7_free_count <= V7FreeMax) &&
                     (state_i.v7_inode_count <= InodeMax);
  assign v6_common = (state_i.size_two <= V6FreeMax) &&
                     (state_i.v6_inode_count <= InodeMax);

  assign pdp_fit = fits(size_pdp, state_i.isize, block_number_i, image_blocks_i);
  assign vax_fit = fits(size_vax, state_i.isize, block_number_i, image_blocks_i);
  assign v6_fit  = fits(size_v6, state_i.isize, block_number_i, image_blocks_i);

  always_comb begin
    kind_d = KIND_NONE;
    isz_d  = 16'd0;
    fsz_d  = 32'd0;
    if (state_i.isize >= MinIsize) begin
      if (v7_common && pdp_fit && state_i.pdp_ok) begin
        kind_d = KIND_V7;
        fsz_d  = size_pdp;
      end else if (v7_common && vax_fit && state_i.vax_ok) begin
        kind_d = KIND_32V;
        fsz_d  = size_vax;
      end else if (v6_common && v6_fit && state_i.v6_ok) begin
        kind_d = KIND_V6;
        fsz_d  = size_v6;
      end
      if (kind_d != KIND_NONE) begin
        isz_d = state_i.isize;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kind_d;
      isz_q  <= isz_d;
      fsz_q  <= fsz_d;
    end
  end

  assign out_valid_o         = valid_q;
  assign fs_kind_o           = kind_q;
  assign inode_area_blocks_o = isz_q;
  assign fs_blocks_o         = fsz_q;

endmodule

>>> design/unix_superblock_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_superblock_classifier_unit
// Classifies a candidate 512-byte block as a V7, 32V or V6 superblock.
// ----------------------------------------------------------------------------
// Usage: the sender streams the block as 16-bit words on the slave channel,
// block number and word in tdata, tlast on the final word. Each beat is taken
// into an input register and checked there against the header fields already
// captured, so the block takes one beat per cycle unless a pending result holds
// its tlast beat. One result beat (kind in tuser, inode-area and filesystem
// sizes in tdata) is loaded into the result register when the tlast beat
// leaves the input register; other beats give no result. If the receiver
// stalls, the result waits in its register while the words of the next block
// keep flowing at full rate; only when that block's tlast beat reaches the
// input register does s_axis_tready drop, until the pending result is taken.
// image_blocks is written over the APB port at address 0; the user must write
// it only while the unit is idle, which the unit itself does not enforce.
// Reset clears all block state, the image size register and both channels;
// the first beat can be accepted in the cycle after reset.
// ----------------------------------------------------------------------------
module unix_superblock_classifier_unit import usc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Word input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] block_number, [47:32] data_word
  input  logic        s_axis_tlast,   // last word of the block
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] inode_area_blocks, [47:16] fs_blocks
  output logic [1:0]  m_axis_tuser    // [1:0] fs_kind
);

  logic [31:0] image_blocks_q;
  logic        reg_hit;

  logic        s1_valid_q;
  logic [31:0] s1_bno_q;
  logic [15:0] s1_word_q;
  logic        s1_last_q;

  logic        advance;
  logic        load_result;
  logic        in_fire;
  blk_state_t  state_next;
  fs_kind_e    res_kind;
  logic [15:0] res_isz;
  logic [31:0] res_fsz;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? image_blocks_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_blocks_q <= 32'd0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      image_blocks_q <= pwdata;
    end
  end

  // A non-last beat always moves on; a last beat needs room for its result.
  assign advance       = s1_valid_q && (!s1_last_q || !m_axis_tvalid || m_axis_tready);
  assign load_result   = advance && s1_last_q;
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bno_q  <= s_axis_tdata[31:0];
      s1_word_q <= s_axis_tdata[47:32];
      s1_last_q <= s_axis_tlast;
    end
  end

  usc_block_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_en_i    (advance),
    .word_i       (s1_word_q),
    .last_i       (s1_last_q),
    .state_next_o (state_next)
  );

  usc_verdict u_verdict (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .load_i              (load_result),
    .state_i             (state_next),
    .block_number_i      (s1_bno_q),
    .image_blocks_i      (image_blocks_q),
    .out_ready_i         (m_axis_tready),
    .out_valid_o         (m_axis_tvalid),
    .fs_kind_o           (res_kind),
    .inode_area_blocks_o (res_isz),
    .fs_blocks_o         (res_fsz)
  );

  assign m_axis_tdata = {res_fsz, res_isz};
  assign m_axis_tuser = res_kind;

endmodule

>>> design/usc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module usc_checker import usc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A result beat holds until the receiver takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A rejected block reports zero sizes.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_NONE) |-> m_axis_tdata == 48'd0)
    else $error("nonzero sizes on a rejected block");

  // An accepted superblock always has an inode area of at least the minimum.
  a_isize_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_NONE) |-> m_axis_tdata[15:0] >= MinIsize)
    else $error("accepted superblock with too small an inode area");

  // A fresh result follows an accepted last input beat.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result beat without a last input beat");

  // With no result pending, the input side never stalls.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with the output empty");

endmodule

bind unix_superblock_classifier_unit usc_checker u_usc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
